/* hw/rtl/mean_threshold_cursor_bitmap_assert.svh */
// Assertion macros used by the mean-threshold cursor bitmap back end sequencer
`ifndef MEAN_THRESHOLD_CURSOR_BITMAP_ASSERT_SVH
`define MEAN_THRESHOLD_CURSOR_BITMAP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MTCB_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mtcb: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset
`define MTCB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mtcb: next-cycle check failed");

`endif

/* hw/rtl/mtcb_pkg.sv */
// Package: constants, types and codes of the mean-threshold cursor bitmap block
`timescale 1ns / 1ps
`default_nettype none
package mtcb_pkg;
	localparam int MAX_WIDTH   = 64;
	localparam int MAX_HEIGHT  = 64;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int POS_W       = $clog2(STORE_DEPTH + 1);
	localparam int SUM_W       = $clog2(255 * STORE_DEPTH + 1);
	localparam int DIV_W       = SUM_W + 9;
	localparam int DIM_W       = 7;
	localparam int IDX_W       = 9;
	localparam int BINS        = 256;
	localparam int FIFO_DEPTH  = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [15:0] W_RED   = 16'd13933;
	localparam logic [15:0] W_GREEN = 16'd46871;
	localparam logic [15:0] W_BLUE  = 16'd4732;

	typedef enum logic [1:0] {
		K_CLEAR  = 2'd0,
		K_LOAD   = 2'd1,
		K_FINISH = 2'd2,
		K_READ   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_OPAQUE = 2'd1,
		ST_FG_EMPTY  = 2'd2,
		ST_BG_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALPHA_LIMIT  = 2'd0,
		CFG_IMAGE_WIDTH  = 2'd1,
		CFG_IMAGE_HEIGHT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]       alpha_limit;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
	} cfg_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       grey;
		logic             opaque;
		logic [IDX_W-1:0] byte_index;
	} cmd_t;
endpackage
`default_nettype wire

/* hw/rtl/mtcb_front.sv */
// Front end: accept transactions, work out luma and opacity, push commands
`timescale 1ns / 1ps
`default_nettype none
module mtcb_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mtcb_pkg::cfg_t cfg,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [1:0]    kind,
	input  wire logic [7:0]    red,
	input  wire logic [7:0]    green,
	input  wire logic [7:0]    blue,
	input  wire logic [7:0]    alpha,
	input  wire logic [8:0]    byte_index,
	output logic               push_valid,
	input  wire logic          push_ready,
	output mtcb_pkg::cmd_t     push_cmd
);
	import mtcb_pkg::*;

	logic             vld_s1;
	kind_t            kind_s1;
	logic [23:0]      pr_s1, pg_s1, pb_s1;
	logic             opq_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [23:0]      luma_sum;

	assign in_ready = !vld_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// weighted products, one multiplier each, registered before the sum
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind_t'(kind);
			pr_s1   <= 24'(W_RED * red);
			pg_s1   <= 24'(W_GREEN * green);
			pb_s1   <= 24'(W_BLUE * blue);
			opq_s1  <= (alpha >= cfg.alpha_limit);
			idx_s1  <= byte_index;
		end
	end

	assign luma_sum            = pr_s1 + pg_s1 + pb_s1;
	assign push_valid          = vld_s1;
	assign push_cmd.kind       = kind_s1;
	assign push_cmd.grey       = luma_sum[23:16];
	assign push_cmd.opaque     = opq_s1;
	assign push_cmd.byte_index = idx_s1;
endmodule
`default_nettype wire

/* hw/rtl/mtcb_fifo.sv */
// Short command queue between the front end and the sequencer
`timescale 1ns / 1ps
`default_nettype none
module mtcb_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire mtcb_pkg::cmd_t push_cmd,
	output logic                pop_valid,
	input  wire logic           pop,
	output mtcb_pkg::cmd_t      pop_cmd
);
	import mtcb_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	cmd_t               mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wp_q, rp_q;
	logic [PTR_W:0]     cnt_q;
	logic               do_push, do_pop;

	assign push_ready = (cnt_q != (PTR_W+1)'(FIFO_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_cmd    = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + 1'b1;
			if (do_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= push_cmd;
	end
endmodule
`default_nettype wire

/* hw/rtl/mtcb_div.sv */
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module mtcb_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [mtcb_pkg::DIV_W-1:0]    dividend,
	input  wire logic [mtcb_pkg::POS_W-1:0]    divisor,
	output logic                               done,
	output logic [mtcb_pkg::DIV_W-1:0]         quot,
	output logic [mtcb_pkg::POS_W-1:0]         rem
);
	import mtcb_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [POS_W-1:0] rem_q, dsr_q;
	logic [POS_W:0]   shifted;
	logic             ge;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign ge      = (shifted >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? POS_W'(shifted - {1'b0, dsr_q}) : shifted[POS_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

/* hw/rtl/mtcb_back.sv */
// Back end sequencer: stores, histogram, threshold walk, levels and bitmap reads
`timescale 1ns / 1ps
`default_nettype none
`include "mean_threshold_cursor_bitmap_assert.svh"
module mtcb_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mtcb_pkg::cfg_t cfg,
	input  wire logic           cmd_valid,
	input  wire mtcb_pkg::cmd_t cmd,
	output logic                cmd_pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [15:0]         fg_level,
	output logic [15:0]         bg_level,
	output logic [7:0]          cursor_byte,
	output logic [7:0]          mask_byte,
	output logic [1:0]          status
);
	import mtcb_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_WALK, S_FG_GO, S_FG_WAIT, S_BG_GO, S_BG_WAIT,
		S_RD_WAIT, S_RD_PIX, S_RESULT
	} state_t;

	state_t           state_q;
	logic [POS_W-1:0] pos_q, cnt_q, scnt_q;
	logic [SUM_W-1:0] sum_q, ssum_q;
	logic [7:0]       grey_q, cur_q, msk_q;
	logic [8:0]       walk_q;
	logic [15:0]      fg_q, bg_q;
	status_t          status_q;
	logic [IDX_W-1:0] row_q;
	logic [2:0]       colb_q;
	logic [3:0]       bit_q;
	logic             pv_s1, out_valid_q;

	// result register, loaded when a result leaves the sequencer
	logic [15:0]      out_fg_q, out_bg_q;
	logic [7:0]       out_cur_q, out_msk_q;
	status_t          out_st_q;
	logic             res_load;

	// stores and histogram
	logic [8:0]       store_mem [STORE_DEPTH];
	logic [8:0]       st_rd_q;
	logic [POS_W-1:0] hist_mem [BINS];
	logic [BINS-1:0]  hist_vld_q;
	logic [POS_W-1:0] hist_rd_q;
	logic             hvr_q;
	logic [7:0]       hra;
	logic             hwe;
	logic [POS_W-1:0] hbin;

	logic [DIM_W-1:0] ew, eh;
	logic [POS_W-1:0] wh;
	logic [3:0]       bpr;
	logic             load_ok;

	logic [7:0]       wi;
	logic [20:0]      wi_cnt, wi_bin;
	logic [SUM_W-1:0] bsum;
	logic [POS_W-1:0] bcnt;

	logic [5:0]       px_x;
	logic [15:0]      px_p;
	logic             px_v;
	logic [2:0]       prev_bit;
	logic [20:0]      px_gc;

	logic             div_start, div_done;
	logic [DIV_W-1:0] div_nd, div_q;
	logic [POS_W-1:0] div_ds, div_r;

	// effective image size
	always_comb begin
		if (cfg.image_width == '0) ew = DIM_W'(1);
		else if (cfg.image_width > DIM_W'(MAX_WIDTH)) ew = DIM_W'(MAX_WIDTH);
		else ew = cfg.image_width;
		if (cfg.image_height == '0) eh = DIM_W'(1);
		else if (cfg.image_height > DIM_W'(MAX_HEIGHT)) eh = DIM_W'(MAX_HEIGHT);
		else eh = cfg.image_height;
	end
	assign wh      = POS_W'(ew * eh);
	assign bpr     = 4'((ew + DIM_W'(7)) >> 3);
	assign load_ok = (pos_q < wh);

	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign res_load = (state_q == S_RESULT) && (!out_valid_q || out_ready);

	// histogram port: read on the pop of a load, else walk address
	assign hra  = (state_q == S_IDLE) ? cmd.grey : walk_q[7:0];
	assign hwe  = (state_q == S_LOAD);
	assign hbin = hvr_q ? hist_rd_q : '0;

	always_ff @(posedge clk) begin
		hist_rd_q <= hist_mem[hra];
		if (hwe) hist_mem[grey_q] <= hbin + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			hvr_q      <= 1'b0;
		end else begin
			hvr_q <= hist_vld_q[hra];
			if (cmd_pop && cmd.kind == K_CLEAR) hist_vld_q <= '0;
			else if (hwe) hist_vld_q[grey_q] <= 1'b1;
		end
	end

	// walk arithmetic for the previous bin
	assign wi     = 8'(walk_q - 9'd1);
	assign wi_cnt = 21'(wi * cnt_q);
	assign wi_bin = 21'(wi * hbin);
	assign bsum   = sum_q - ssum_q;
	assign bcnt   = cnt_q - scnt_q;

	// bitmap pixel address for the current bit
	assign px_x     = {colb_q, bit_q[2:0]};
	assign px_p     = 16'(row_q * ew) + 16'(px_x);
	assign px_v     = !bit_q[3] && ({1'b0, px_x} < ew) && (px_p < 16'(pos_q));
	assign prev_bit = 3'(bit_q - 4'd1);
	assign px_gc    = 21'(st_rd_q[7:0] * cnt_q);

	always_ff @(posedge clk) begin
		st_rd_q <= store_mem[px_p[ADDR_W-1:0]];
		if (cmd_pop && cmd.kind == K_LOAD && load_ok)
			store_mem[pos_q[ADDR_W-1:0]] <= {cmd.opaque, cmd.grey};
	end

	// divider shared by the level divisions and the byte index split
	always_comb begin
		div_start = 1'b0;
		div_nd    = DIV_W'(cmd.byte_index);
		div_ds    = POS_W'(bpr);
		unique case (state_q)
			S_IDLE: div_start = cmd_pop && (cmd.kind == K_READ);
			S_FG_GO: begin
				div_start = (bcnt != '0);
				div_nd    = {bsum, 8'd0} + DIV_W'(bsum);
				div_ds    = bcnt;
			end
			S_BG_GO: begin
				div_start = (scnt_q != '0);
				div_nd    = {ssum_q, 8'd0} + DIV_W'(ssum_q);
				div_ds    = scnt_q;
			end
			default: div_start = 1'b0;
		endcase
	end

	mtcb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_nd),
		.divisor  (div_ds),
		.done     (div_done),
		.quot     (div_q),
		.rem      (div_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			cnt_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			walk_q      <= '0;
			bit_q       <= '0;
		end else begin
			// hold a waiting result, raise valid whenever a new one is loaded
			out_valid_q <= (state_q == S_RESULT) || (out_valid_q && !out_ready);
			unique case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						unique case (cmd.kind)
							K_CLEAR: begin
								pos_q <= '0;
								cnt_q <= '0;
								sum_q <= '0;
							end
							K_LOAD: begin
								if (load_ok) begin
									pos_q <= pos_q + 1'b1;
									if (cmd.opaque) begin
										cnt_q   <= cnt_q + 1'b1;
										sum_q   <= sum_q + SUM_W'(cmd.grey);
										state_q <= S_LOAD;
									end
								end
							end
							K_FINISH: begin
								walk_q  <= '0;
								state_q <= S_WALK;
							end
							K_READ: state_q <= S_RD_WAIT;
						endcase
					end
				end
				S_LOAD: state_q <= S_IDLE;
				S_WALK: begin
					walk_q <= walk_q + 1'b1;
					if (walk_q == 9'(BINS)) state_q <= S_FG_GO;
				end
				S_FG_GO: state_q <= (bcnt != '0) ? S_FG_WAIT : S_BG_GO;
				S_FG_WAIT: if (div_done) state_q <= S_BG_GO;
				S_BG_GO: state_q <= (scnt_q != '0) ? S_BG_WAIT : S_RESULT;
				S_BG_WAIT: if (div_done) state_q <= S_RESULT;
				S_RD_WAIT: begin
					if (div_done) begin
						bit_q   <= '0;
						state_q <= ({1'b0, div_q[IDX_W-1:0]} < 10'(eh)) ? S_RD_PIX : S_RESULT;
					end
				end
				S_RD_PIX: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q[3]) state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (!out_valid_q || out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		if (cmd_pop) grey_q <= cmd.grey;
		if (cmd_pop && cmd.kind == K_FINISH) begin
			ssum_q <= '0;
			scnt_q <= '0;
			cur_q  <= '0;
			msk_q  <= '0;
			fg_q   <= '0;
			bg_q   <= '0;
		end
		if (cmd_pop && cmd.kind == K_READ) begin
			cur_q    <= '0;
			msk_q    <= '0;
			fg_q     <= '0;
			bg_q     <= '0;
			status_q <= ST_OK;
		end
		if (state_q == S_WALK && walk_q != '0) begin
			if (wi_cnt < 21'(sum_q)) begin
				ssum_q <= ssum_q + SUM_W'(wi_bin);
				scnt_q <= scnt_q + hbin;
			end
		end
		if (state_q == S_FG_GO) begin
			if (cnt_q == '0) status_q <= ST_NO_OPAQUE;
			else if (bcnt == '0) status_q <= ST_FG_EMPTY;
			else if (scnt_q == '0) status_q <= ST_BG_EMPTY;
			else status_q <= ST_OK;
		end
		if (state_q == S_FG_WAIT && div_done) fg_q <= div_q[15:0];
		if (state_q == S_BG_WAIT && div_done) bg_q <= div_q[15:0];
		if (state_q == S_RD_WAIT && div_done) begin
			row_q  <= div_q[IDX_W-1:0];
			colb_q <= div_r[2:0];
		end
		if (state_q == S_RD_PIX) begin
			pv_s1 <= px_v;
			if (bit_q != '0 && pv_s1 && st_rd_q[8]) begin
				msk_q[prev_bit] <= 1'b1;
				if (px_gc > 21'(sum_q)) cur_q[prev_bit] <= 1'b1;
			end
		end
		if (res_load) begin
			out_fg_q  <= fg_q;
			out_bg_q  <= bg_q;
			out_cur_q <= cur_q;
			out_msk_q <= msk_q;
			out_st_q  <= status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign fg_level    = out_fg_q;
	assign bg_level    = out_bg_q;
	assign cursor_byte = out_cur_q;
	assign mask_byte   = out_msk_q;
	assign status      = out_st_q;

	`MTCB_ASSERT_IMPL(a_div_done_waited, div_done,
		state_q == S_FG_WAIT || state_q == S_BG_WAIT || state_q == S_RD_WAIT)
	`MTCB_ASSERT_NEXT(a_result_held, state_q == S_RESULT && out_valid_q && !out_ready,
		state_q == S_RESULT)
	`MTCB_ASSERT_IMPL(a_pos_bounded, 1'b1, pos_q <= POS_W'(STORE_DEPTH))
	`MTCB_ASSERT_IMPL(a_count_bounded, 1'b1, cnt_q <= pos_q)
endmodule
`default_nettype wire

/* hw/rtl/mean_threshold_cursor_bitmap.sv */
// Top level of the mean-threshold cursor bitmap block
`timescale 1ns / 1ps
`default_nettype none
// Mean-threshold cursor bitmap. RGBA pixels arrive in raster order as load
// transactions and are turned into an 8-bit luma grey; those with alpha at or
// above alpha_limit are opaque and feed a 256-bin histogram, a count and a sum.
// A finish transaction returns foreground and background 16-bit levels split at
// the mean of the opaque greys, with a status code; a read transaction returns
// one packed cursor byte and one mask byte, least significant bit first. The
// front end takes one transaction per cycle while the queue has room, into a
// four-entry queue. The back end sequencer does a clear or a load in its idle
// state, with an extra state for an opaque load's histogram read-modify-write;
// a finish walks over the bins, then runs up to two divisions in the shared
// divider; a read divides the byte index, then for a row inside the image reads
// pixels through the store port. Results leave through an output register, so
// one waiting result does not stop the sequencer from taking the next command.
// Write the registers only while the block is idle; cfg_ready is always high.
module mean_threshold_cursor_bitmap (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [1:0]                     kind,
	input  wire logic [7:0]                     red,
	input  wire logic [7:0]                     green,
	input  wire logic [7:0]                     blue,
	input  wire logic [7:0]                     alpha,
	input  wire logic [8:0]                     byte_index,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [15:0]                         fg_level,
	output logic [15:0]                         bg_level,
	output logic [7:0]                          cursor_byte,
	output logic [7:0]                          mask_byte,
	output logic [1:0]                          status,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [mtcb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mtcb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mtcb_pkg::*;

	cfg_t cfg_q;
	logic push_valid, push_ready, pop_valid, pop;
	cmd_t push_cmd, pop_cmd;

	// registers are always writable; an unknown index is dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_limit  <= 8'd128;
			cfg_q.image_width  <= DIM_W'(64);
			cfg_q.image_height <= DIM_W'(64);
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ALPHA_LIMIT:  cfg_q.alpha_limit  <= cfg_data;
				CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[DIM_W-1:0];
				CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[DIM_W-1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	// accept and classify
	mtcb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.byte_index (byte_index),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// decouple front end and sequencer
	mtcb_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_cmd    (pop_cmd)
	);

	// carry out commands and hold the result register
	mtcb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd_valid   (pop_valid),
		.cmd         (pop_cmd),
		.cmd_pop     (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.fg_level    (fg_level),
		.bg_level    (bg_level),
		.cursor_byte (cursor_byte),
		.mask_byte   (mask_byte),
		.status      (status)
	);
endmodule
`default_nettype wire

/* tb/mean_threshold_cursor_bitmap_tb.sv */
// Testbench: directed and random transactions against a behavioural predictor
`timescale 1ns / 1ps
module mean_threshold_cursor_bitmap_tb;
	import mtcb_pkg::*;

	// One input transaction and one result transaction
	typedef struct packed {
		kind_t      kind;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		logic [8:0] idx;
	} request_t;

	typedef struct packed {
		logic [15:0] fg;
		logic [15:0] bg;
		logic [7:0]  cur;
		logic [7:0]  mask;
		status_t     st;
	} levels_t;

	// A directed row: the request, whether its result is typed in, and that result
	typedef struct packed {
		request_t req;
		bit       typed;
		levels_t  res;
	} row_t;

	localparam int SETTLE_CYCLES = 400;	// margin for a finish walk and its divisions, plus queued work

	logic clk;
	logic arst_n;
	logic in_valid, in_ready;
	logic [1:0] kind;
	logic [7:0] red, green, blue, alpha;
	logic [8:0] byte_index;
	logic out_valid, out_ready;
	logic [15:0] fg_level, bg_level;
	logic [7:0] cursor_byte, mask_byte;
	logic [1:0] status;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mean_threshold_cursor_bitmap i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .red(red), .green(green), .blue(blue), .alpha(alpha),
		.byte_index(byte_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.fg_level(fg_level), .bg_level(bg_level),
		.cursor_byte(cursor_byte), .mask_byte(mask_byte), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the block's registers and image state
	logic [7:0] sh_alpha_limit;
	logic [6:0] sh_width, sh_height;
	logic [7:0] sh_grey [STORE_DEPTH];
	bit         sh_opaque [STORE_DEPTH];
	int unsigned sh_hist [BINS];
	int unsigned sh_pos, sh_count, sh_sum;

	levels_t pending_results [$];
	int mismatches;
	bit quiet;	// set for the final stretch: no idling on either side

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	// Effective image size: zero counts as one, oversize clamps to the maximum
	function automatic int unsigned span_w();
		if (sh_width == 0) return 1;
		return (sh_width > MAX_WIDTH) ? MAX_WIDTH : sh_width;
	endfunction

	function automatic int unsigned span_h();
		if (sh_height == 0) return 1;
		return (sh_height > MAX_HEIGHT) ? MAX_HEIGHT : sh_height;
	endfunction

	function automatic logic [15:0] class_level(longint unsigned s, longint unsigned n);
		if (n == 0) return 16'd0;
		return 16'((64'd257 * s) / n);
	endfunction

	function automatic void wipe_stats();
		for (int i = 0; i < BINS; i++) sh_hist[i] = 0;
		sh_pos = 0;
		sh_count = 0;
		sh_sum = 0;
	endfunction

	// Advance the shadow state by one request; return 1 when it yields a result
	function automatic bit shadow_step(input request_t q, output levels_t res);
		int unsigned w, h, grey, bpr, row, colb, x, p;
		longint unsigned lo_sum, lo_cnt, hi_sum, hi_cnt;
		w = span_w();
		h = span_h();
		res = '0;
		res.st = ST_OK;
		case (q.kind)
			K_CLEAR: begin
				wipe_stats();
				return 1'b0;
			end
			K_LOAD: begin
				grey = (13933 * q.r + 46871 * q.g + 4732 * q.b) >> 16;
				if (sh_pos >= w * h) return 1'b0;	// beyond the image: drop
				sh_grey[sh_pos] = 8'(grey);
				sh_opaque[sh_pos] = (q.a >= sh_alpha_limit);
				if (q.a >= sh_alpha_limit) begin
					sh_hist[grey]++;
					sh_count++;
					sh_sum += grey;
				end
				sh_pos++;
				return 1'b0;
			end
			K_FINISH: begin
				lo_sum = 0;
				lo_cnt = 0;
				for (int i = 0; i < BINS; i++) begin
					if (longint'(i) * sh_count < longint'(sh_sum)) begin
						lo_sum += longint'(i) * sh_hist[i];
						lo_cnt += sh_hist[i];
					end
				end
				hi_sum = sh_sum - lo_sum;
				hi_cnt = sh_count - lo_cnt;
				if (sh_count == 0) res.st = ST_NO_OPAQUE;
				else if (hi_cnt == 0) res.st = ST_FG_EMPTY;
				else if (lo_cnt == 0) res.st = ST_BG_EMPTY;
				res.fg = class_level(hi_sum, hi_cnt);
				res.bg = class_level(lo_sum, lo_cnt);
				return 1'b1;
			end
			default: begin
				bpr = (w + 7) / 8;
				row = q.idx / bpr;
				colb = q.idx % bpr;
				if (row < h) begin
					for (int k = 0; k < 8; k++) begin
						x = colb * 8 + k;
						p = row * w + x;
						if (x < w && p < sh_pos && sh_opaque[p]) begin
							res.mask[k] = 1'b1;
							if (longint'(sh_grey[p]) * sh_count > longint'(sh_sum))
								res.cur[k] = 1'b1;
						end
					end
				end
				return 1'b1;
			end
		endcase
	endfunction

	// Drive one request, hold it until accepted, then predict its result
	task automatic send(input request_t q, input bit typed, input levels_t typed_res);
		levels_t res;
		bit yields;
		if (!quiet && $urandom_range(3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(13, 1)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= q.kind;
		red        <= q.r;
		green      <= q.g;
		blue       <= q.b;
		alpha      <= q.a;
		byte_index <= q.idx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		yields = shadow_step(q, res);
		if (yields)
			pending_results.insert(pending_results.size(), typed ? typed_res : res);
	endtask

	// Let the block drain before touching a register
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ALPHA_LIMIT:  sh_alpha_limit = data;
			CFG_IMAGE_WIDTH:  sh_width = data[6:0];
			default:          sh_height = data[6:0];
		endcase
	endtask

	function automatic request_t random_pixel();
		request_t q;
		q.kind = K_LOAD;
		q.r = 8'($urandom);
		q.g = 8'($urandom);
		q.b = 8'($urandom);
		q.idx = 9'($urandom);
		// bias alpha towards the opaque limit and the extremes
		case ($urandom_range(3))
			0: q.a = sh_alpha_limit;
			1: q.a = sh_alpha_limit - 8'd1;
			2: q.a = ($urandom_range(1)) ? 8'hFF : 8'h00;
			default: q.a = 8'($urandom);
		endcase
		return q;
	endfunction

	// One phase of random work: mostly clear / load image / finish / read sequences
	task automatic random_phase(input int budget);
		request_t q;
		int done, npix, nread, bpr;
		done = 0;
		while (done < budget) begin
			if ($urandom_range(4) != 0) begin
				q = '0;
				q.kind = K_CLEAR;
				send(q, 1'b0, '0);
				npix = $urandom_range(span_w() * span_h() + 2);
				if (npix > 40) npix = $urandom_range(40, 1);
				for (int i = 0; i < npix; i++) send(random_pixel(), 1'b0, '0);
				q.kind = K_FINISH;
				send(q, 1'b0, '0);
				bpr = (span_w() + 7) / 8;
				nread = $urandom_range(6, 1);
				for (int i = 0; i < nread; i++) begin
					q.kind = K_READ;
					q.idx = ($urandom_range(4) == 0) ? 9'($urandom)
						: 9'($urandom_range(bpr * span_h()));
					send(q, 1'b0, '0);
				end
				done += npix + nread + 2;
			end else begin
				// noise: any kind with any fields
				q = random_pixel();
				q.kind = kind_t'($urandom_range(3));
				send(q, 1'b0, '0);
				done++;
			end
		end
	endtask

	// Receiver: random stall bursts, none in the final stretch
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (quiet) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(13, 1) * ($urandom_range(3) == 0 ? 4 : 1)) @(posedge clk);
				if (!quiet) begin
					out_ready <= 1'b0;
					repeat ($urandom_range(13, 1)) @(posedge clk);
				end
			end
		end
	end

	// Check each accepted result against the oldest prediction
	always @(posedge clk) begin
		levels_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: fg %0d bg %0d cur %h mask %h st %0d",
						fg_level, bg_level, cursor_byte, mask_byte, status);
			end else begin
				want = pending_results.pop_front();
				if (fg_level !== want.fg || bg_level !== want.bg
						|| cursor_byte !== want.cur || mask_byte !== want.mask
						|| status !== want.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp fg %0d bg %0d cur %h mask %h st %0d, ",
							want.fg, want.bg, want.cur, want.mask, want.st,
							"got fg %0d bg %0d cur %h mask %h st %0d",
							fg_level, bg_level, cursor_byte, mask_byte, status);
				end
			end
		end
	end

	// Directed table. Typed results: after reset, a single white pixel,
	// and two greys sitting exactly on the mean. The rest go to the predictor.
	row_t directed [] = '{
		'{'{K_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0}, 1'b1, '{16'd0, 16'd0, 8'd0, 8'd0, ST_NO_OPAQUE}},
		'{'{K_READ, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0}, 1'b1, '{16'd0, 16'd0, 8'd0, 8'd0, ST_OK}},
		'{'{K_LOAD, 8'd255, 8'd255, 8'd255, 8'd255, 9'd0}, 1'b0, '0},
		'{'{K_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0}, 1'b1, '{16'd65535, 16'd0, 8'd0, 8'd0, ST_BG_EMPTY}},
		'{'{K_LOAD, 8'd0, 8'd0, 8'd0, 8'd128, 9'd0}, 1'b0, '0},
		'{'{K_LOAD, 8'd0, 8'd0, 8'd0, 8'd127, 9'd0}, 1'b0, '0},
		'{'{K_LOAD, 8'd255, 8'd0, 8'd0, 8'd200, 9'd0}, 1'b0, '0},
		'{'{K_LOAD, 8'd0, 8'd255, 8'd0, 8'd255, 9'd0}, 1'b0, '0},
		'{'{K_LOAD, 8'd0, 8'd0, 8'd255, 8'd255, 9'd0}, 1'b0, '0},
		'{'{K_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0}, 1'b0, '0},
		'{'{K_READ, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0}, 1'b0, '0},
		'{'{K_READ, 8'd0, 8'd0, 8'd0, 8'd0, 9'd511}, 1'b0, '0},
		'{'{K_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0}, 1'b0, '0},
		'{'{K_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0}, 1'b1, '{16'd0, 16'd0, 8'd0, 8'd0, ST_NO_OPAQUE}},
		'{'{K_LOAD, 8'd100, 8'd100, 8'd100, 8'd255, 9'd0}, 1'b0, '0},
		'{'{K_LOAD, 8'd100, 8'd100, 8'd100, 8'd255, 9'd0}, 1'b0, '0},
		'{'{K_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0}, 1'b1, '{16'd25700, 16'd0, 8'd0, 8'd0, ST_BG_EMPTY}},
		'{'{K_READ, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0}, 1'b1, '{16'd0, 16'd0, 8'd0, 8'd3, ST_OK}},
		'{'{K_LOAD, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0}, 1'b0, '0},
		'{'{K_LOAD, 8'd255, 8'd255, 8'd255, 8'd128, 9'd0}, 1'b0, '0},
		'{'{K_READ, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0}, 1'b0, '0},
		'{'{K_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0}, 1'b0, '0}
	};

	// Register settings per random phase: alpha limit, width, height
	logic [7:0] phase_cfg [8][3] = '{
		'{8'd0,   8'd8,   8'd4},
		'{8'd255, 8'd1,   8'd1},
		'{8'd77,  8'd0,   8'd0},
		'{8'd200, 8'd255, 8'd3},
		'{8'd90,  8'd13,  8'd5},
		'{8'd30,  8'd3,   8'd64},
		'{8'd128, 8'd64,  8'd2},
		'{8'd160, 8'd21,  8'd6}
	};

	initial begin
		int gap;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = 2'd0;
		red = 8'd0;
		green = 8'd0;
		blue = 8'd0;
		alpha = 8'd0;
		byte_index = 9'd0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		quiet = 1'b0;
		sh_alpha_limit = 8'd128;
		sh_width = 7'd64;
		sh_height = 7'd64;
		wipe_stats();
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		foreach (directed[i]) send(directed[i].req, directed[i].typed, directed[i].res);

		for (int p = 0; p < 8; p++) begin
			wait_idle();
			write_reg(CFG_ALPHA_LIMIT, phase_cfg[p][0]);
			write_reg(CFG_IMAGE_WIDTH, phase_cfg[p][1]);
			write_reg(CFG_IMAGE_HEIGHT, phase_cfg[p][2]);
			if (p == 7) quiet = 1'b1;	// final stretch runs flat out
			random_phase(p == 7 ? 60 : 80);
		end
		in_valid <= 1'b0;

		// drain, then let any trailing work settle
		gap = 0;
		while (pending_results.size() != 0 && gap < 200_000) begin
			@(posedge clk);
			gap++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

/* mean_threshold_cursor_bitmap.f */
+incdir+hw/rtl
hw/rtl/mtcb_pkg.sv
hw/rtl/mtcb_front.sv
hw/rtl/mtcb_fifo.sv
hw/rtl/mtcb_div.sv
hw/rtl/mtcb_back.sv
hw/rtl/mean_threshold_cursor_bitmap.sv
tb/mean_threshold_cursor_bitmap_tb.sv
